// ===== design/pid_wheel_move_controller_assert.svh =====
// Assertion helpers shared by the controller and the datapath.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef PID_WHEEL_MOVE_CONTROLLER_ASSERT_SVH
`define PID_WHEEL_MOVE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PWMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PWMC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PWMC_ASSERT(lbl, prop, msg)
`define PWMC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/pwmc_pkg.sv =====
package pwmc_pkg;

  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;
  localparam int GAIN_W  = 20;
  localparam int SPD_W   = 15;
  localparam int TOL_W   = 16;
  localparam int TGT_W   = 32;
  localparam int ERR_W   = 33;
  localparam int DIFF_W  = 34;
  localparam int INT_W   = 48;
  localparam int PROD_W  = 68;
  localparam int TERM_W  = 51;
  localparam int ACC_W   = 53;
  localparam int DRV_W   = 16;
  localparam int C_W     = 18;
  localparam int QUO_W   = 18;
  localparam int FRAC_G  = 12;

  localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'(1) << 50;
  localparam logic signed [C_W-1:0] C_MAX = 18'sd65536;
  localparam logic signed [C_W-1:0] C_MIN = -18'sd65536;

  // register map
  typedef enum logic [IDX_W-1:0] {
    CFG_KP_T  = 3'd0,
    CFG_KI_T  = 3'd1,
    CFG_KD_T  = 3'd2,
    CFG_KP_R  = 3'd3,
    CFG_KI_R  = 3'd4,
    CFG_KD_R  = 3'd5,
    CFG_SPEED = 3'd6,
    CFG_TOL   = 3'd7
  } cfg_idx_e;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NONE,
    DP_START,
    DP_LOAD,
    DP_ERR,
    DP_MUL_P,
    DP_MUL_I,
    DP_MUL_D,
    DP_ACC,
    DP_CLAMP,
    DP_C_SAT,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_CSET,
    DP_MUL_A,
    DP_MUL_B,
    DP_FIN_B,
    DP_EMIT_DRIVE,
    DP_EMIT_STOP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic rotate;
    logic r_zero;
    logic big_ratio;
    logic within_tol;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/pwmc_if.sv =====
interface pwmc_in_if #(
  parameter int TICK_WIDTH = 24
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic                         move_mode;
  logic signed [31:0]           goal_ticks;
  logic signed [TICK_WIDTH-1:0] left_ticks;
  logic signed [TICK_WIDTH-1:0] right_ticks;

  modport source (output valid, kind, move_mode, goal_ticks, left_ticks, right_ticks,
                  input ready);
  modport sink (input valid, kind, move_mode, goal_ticks, left_ticks, right_ticks,
                output ready);
endinterface

interface pwmc_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic               move_done;
  logic               last;

  modport source (output valid, left_drive, right_drive, move_done, last, input ready);
  modport sink (input valid, left_drive, right_drive, move_done, last, output ready);
endinterface

// ===== design/pid_wheel_move_controller.sv =====
// PID wheel move controller. A start transfer (kind 0) loads a translate or rotate move;
// it gives no result. An encoder sample (kind 1) during a move is worked through a
// shared 48x20 multiplier, one PID term per cycle: a translate sample goes through the
// error, PID and clamp states to its drive result; a rotate sample then also has its wheel
// balance kept when the right count is zero, saturated, or recomputed by the bit-serial
// 18-step divider, before its two balance products. A finishing sample also gives a zero
// stop result marked done, loaded once the drive result has left the output register.
// The next input transfer can follow in the cycle after the last result is loaded.
// Samples while idle are dropped. The input stalls only while a sample is in work or a
// result waits behind a full output register.
module pid_wheel_move_controller #(
  parameter int TICK_WIDTH = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pwmc_in_if.sink                    in_if,
  pwmc_out_if.source                 out_if,
  input  logic                       cfg_we_i,
  input  logic [pwmc_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [pwmc_pkg::CFG_W-1:0] cfg_data_i
);

  pwmc_pkg::dp_cmd_t    cmd;
  pwmc_pkg::dp_status_t status;

  pwmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.kind),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pwmc_dp #(
    .TICK_WIDTH (TICK_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .move_mode_i    (in_if.move_mode),
    .goal_ticks_i   (in_if.goal_ticks),
    .left_ticks_i   (in_if.left_ticks),
    .right_ticks_i  (in_if.right_ticks),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .left_drive_o   (out_if.left_drive),
    .right_drive_o  (out_if.right_drive),
    .move_done_o    (out_if.move_done),
    .last_o         (out_if.last)
  );

endmodule

// ===== design/pwmc_dp.sv =====
`include "pid_wheel_move_controller_assert.svh"

module pwmc_dp #(
  parameter int TICK_WIDTH = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pwmc_pkg::dp_cmd_t            cmd_i,
  output pwmc_pkg::dp_status_t         status_o,
  input  logic                         cfg_we_i,
  input  logic [pwmc_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [pwmc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         move_mode_i,
  input  logic signed [31:0]           goal_ticks_i,
  input  logic signed [TICK_WIDTH-1:0] left_ticks_i,
  input  logic signed [TICK_WIDTH-1:0] right_ticks_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           left_drive_o,
  output logic signed [15:0]           right_drive_o,
  output logic                         move_done_o,
  output logic                         last_o
);

  localparam int TW = TICK_WIDTH;
  localparam int PW = TICK_WIDTH + FRAC_BITS + 2;
  localparam int EW = ((PW > 33) ? PW : 33) + 1;
  localparam logic signed [EW-1:0] EMAX = EW'(64'sd4294967295);
  localparam logic signed [EW-1:0] EMIN = EW'(-64'sd4294967296);

  // configuration
  logic [19:0] kp_t_q, ki_t_q, kd_t_q, kp_r_q, ki_r_q, kd_r_q;
  logic [14:0] speed_q;
  logic [15:0] tol_q;

  // move state
  logic                      rotate_q, rev_q;
  logic [31:0]               tmag_q;
  logic signed [47:0]        int_q;
  logic signed [32:0]        prev_q;
  logic signed [17:0]        c_q;

  // working registers
  logic signed [TW-1:0]      l_q, r_q;
  logic signed [32:0]        err_q;
  logic signed [33:0]        diff_q;
  logic [67:0]               prod_q;
  logic                      psign_q;
  logic signed [52:0]        acc_q;
  logic signed [15:0]        u_q;
  logic signed [15:0]        left_q, right_q;
  logic [TW+15:0]            rem_q;
  logic [TW+17:0]            dsh_q;
  logic [17:0]               quo_q;

  logic                      out_valid_q;
  logic signed [15:0]        out_l_q, out_r_q;
  logic                      out_done_q, out_last_q;

  logic [TW-1:0]             lmag, rmag;
  logic [TW:0]               msum;
  logic signed [TW:0]        tsum;
  logic signed [PW-1:0]      prog_base, prog;
  logic signed [EW-1:0]      ediff;
  logic signed [32:0]        err_d;
  logic signed [48:0]        isum;
  logic signed [47:0]        int_d;
  logic signed [33:0]        diff_d;
  logic [32:0]               emag;
  logic [47:0]               imag;
  logic [33:0]               dmag;
  logic [15:0]               umag;
  logic [47:0]               mul_a;
  logic [19:0]               mul_b;
  logic                      mul_sign;
  logic [19:0]               kp_sel, ki_sel, kd_sel;
  logic signed [19:0]        fa, fb;
  logic [50:0]               tmag;
  logic signed [52:0]        term;
  logic signed [52:0]        ash, lim;
  logic signed [15:0]        u_d;
  logic                      div_ge;
  logic signed [19:0]        cd;
  logic [31:0]               tgt_mag;

  // magnitude on a rotation product, shift, direction and saturation
  function automatic logic signed [15:0] rot_drive(logic [67:0] p, logic neg_p, logic flip);
    logic signed [35:0] ps, sh, v;
    begin
      ps = neg_p ? -$signed(p[35:0]) : $signed(p[35:0]);
      sh = ps >>> 17;
      v  = flip ? -sh : sh;
      if (v > 36'sd32767) begin
        rot_drive = 16'sh7fff;
      end else if (v < -36'sd32768) begin
        rot_drive = -16'sd32768;
      end else begin
        rot_drive = v[15:0];
      end
    end
  endfunction

  // progress and error
  always_comb begin
    lmag      = l_q[TW-1] ? TW'(-l_q) : TW'(l_q);
    rmag      = r_q[TW-1] ? TW'(-r_q) : TW'(r_q);
    msum      = {1'b0, lmag} + {1'b0, rmag};
    tsum      = $signed({l_q[TW-1], l_q}) + $signed({r_q[TW-1], r_q});
    prog_base = rotate_q ? $signed({{(PW-TW-1){1'b0}}, msum}) : PW'(tsum);
    prog      = (prog_base <<< FRAC_BITS) >>> 1;
    ediff     = $signed({{(EW-32){1'b0}}, tmag_q}) - EW'(prog);
    if (ediff > EMAX) begin
      err_d = 33'sh0ffffffff;
    end else if (ediff < EMIN) begin
      err_d = -33'sh100000000;
    end else begin
      err_d = ediff[32:0];
    end
    isum = 49'(int_q) + 49'(err_d);
    if (isum[48] != isum[47]) begin
      int_d = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      int_d = isum[47:0];
    end
    diff_d  = 34'(err_d) - 34'(prev_q);
    tgt_mag = goal_ticks_i[31] ? 32'(-goal_ticks_i) : 32'(goal_ticks_i);
  end

  // multiplier operand selection
  always_comb begin
    emag   = err_q[32] ? 33'(-err_q) : 33'(err_q);
    imag   = int_q[47] ? 48'(-int_q) : 48'(int_q);
    dmag   = diff_q[33] ? 34'(-diff_q) : 34'(diff_q);
    umag   = u_q[15] ? 16'(-u_q) : 16'(u_q);
    kp_sel = rotate_q ? kp_r_q : kp_t_q;
    ki_sel = rotate_q ? ki_r_q : ki_t_q;
    kd_sel = rotate_q ? kd_r_q : kd_t_q;
    fa     = 20'sd131072 + 20'(c_q);
    fb     = 20'sd131072 - 20'(c_q);
    mul_a    = '0;
    mul_b    = '0;
    mul_sign = 1'b0;
    case (cmd_i.op)
      pwmc_pkg::DP_MUL_P: begin
        mul_a = 48'(emag); mul_b = kp_sel; mul_sign = err_q[32];
      end
      pwmc_pkg::DP_MUL_I: begin
        mul_a = imag; mul_b = ki_sel; mul_sign = int_q[47];
      end
      pwmc_pkg::DP_MUL_D: begin
        mul_a = 48'(dmag); mul_b = kd_sel; mul_sign = diff_q[33];
      end
      pwmc_pkg::DP_MUL_A: begin
        mul_a = 48'(umag); mul_b = fa; mul_sign = u_q[15];
      end
      pwmc_pkg::DP_MUL_B: begin
        mul_a = 48'(umag); mul_b = fb; mul_sign = u_q[15];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // saturated PID term, output clamp, divider compare, balance update
  always_comb begin
    tmag   = (prod_q > pwmc_pkg::TERM_LIM) ? 51'(pwmc_pkg::TERM_LIM) : prod_q[50:0];
    term   = psign_q ? -$signed({2'b0, tmag}) : $signed({2'b0, tmag});
    ash    = acc_q >>> pwmc_pkg::FRAC_G;
    lim    = $signed({38'b0, speed_q});
    if (ash > lim) begin
      u_d = lim[15:0];
    end else if (ash < -lim) begin
      u_d = 16'(-lim);
    end else begin
      u_d = ash[15:0];
    end
    div_ge = {2'b0, rem_q} >= dsh_q;
    cd     = 20'sd65536 - $signed({2'b0, quo_q});
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_t_q  <= 20'd3277;
      ki_t_q  <= 20'd10;
      kd_t_q  <= 20'd16384;
      kp_r_q  <= 20'd4096;
      ki_r_q  <= 20'd0;
      kd_r_q  <= 20'd0;
      speed_q <= 15'd768;
      tol_q   <= 16'd768;
    end else if (cfg_we_i) begin
      case (pwmc_pkg::cfg_idx_e'(cfg_index_i))
        pwmc_pkg::CFG_KP_T:  kp_t_q  <= cfg_data_i;
        pwmc_pkg::CFG_KI_T:  ki_t_q  <= cfg_data_i;
        pwmc_pkg::CFG_KD_T:  kd_t_q  <= cfg_data_i;
        pwmc_pkg::CFG_KP_R:  kp_r_q  <= cfg_data_i;
        pwmc_pkg::CFG_KI_R:  ki_r_q  <= cfg_data_i;
        pwmc_pkg::CFG_KD_R:  kd_r_q  <= cfg_data_i;
        pwmc_pkg::CFG_SPEED: speed_q <= cfg_data_i[14:0];
        pwmc_pkg::CFG_TOL:   tol_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q <= 1'b0;
      rev_q    <= 1'b0;
      tmag_q   <= '0;
      int_q    <= '0;
      prev_q   <= '0;
      c_q      <= '0;
    end else begin
      case (cmd_i.op)
        pwmc_pkg::DP_START: begin
          rotate_q <= move_mode_i;
          rev_q    <= goal_ticks_i[31] || (goal_ticks_i == 32'sd0);
          tmag_q   <= tgt_mag;
          int_q    <= '0;
          prev_q   <= '0;
          c_q      <= '0;
        end
        pwmc_pkg::DP_ERR: begin
          int_q  <= int_d;
          prev_q <= err_d;
        end
        pwmc_pkg::DP_C_SAT: c_q <= pwmc_pkg::C_MIN;
        pwmc_pkg::DP_CSET: c_q <= (cd < -20'sd65536) ? pwmc_pkg::C_MIN : cd[17:0];
        default: ;
      endcase
    end
  end

  // working registers, one operation per cycle
  always_ff @(posedge clk_i) begin
    prod_q  <= {20'b0, mul_a} * {48'b0, mul_b};
    psign_q <= mul_sign;
    case (cmd_i.op)
      pwmc_pkg::DP_LOAD: begin
        l_q <= left_ticks_i;
        r_q <= right_ticks_i;
      end
      pwmc_pkg::DP_ERR: begin
        err_q  <= err_d;
        diff_q <= diff_d;
      end
      pwmc_pkg::DP_MUL_I: acc_q <= term;
      pwmc_pkg::DP_MUL_D: acc_q <= acc_q + term;
      pwmc_pkg::DP_ACC:   acc_q <= acc_q + term;
      pwmc_pkg::DP_CLAMP: begin
        u_q     <= u_d;
        left_q  <= rev_q ? -u_d : u_d;
        right_q <= rev_q ? -u_d : u_d;
      end
      pwmc_pkg::DP_DIV_INIT: begin
        rem_q <= {lmag, 16'b0};
        dsh_q <= {1'b0, rmag, 17'b0};
        quo_q <= '0;
      end
      pwmc_pkg::DP_DIV_STEP: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh_q[TW+15:0];
        end
        quo_q <= {quo_q[16:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      pwmc_pkg::DP_MUL_B: left_q  <= rot_drive(prod_q, psign_q, !rev_q);
      pwmc_pkg::DP_FIN_B: right_q <= rot_drive(prod_q, psign_q, rev_q);
      default: ;
    endcase
  end

  // output register: load on emit, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == pwmc_pkg::DP_EMIT_DRIVE || cmd_i.op == pwmc_pkg::DP_EMIT_STOP) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pwmc_pkg::DP_EMIT_DRIVE) begin
      out_l_q    <= left_q;
      out_r_q    <= right_q;
      out_done_q <= 1'b0;
      out_last_q <= !status_o.within_tol;
    end else if (cmd_i.op == pwmc_pkg::DP_EMIT_STOP) begin
      out_l_q    <= '0;
      out_r_q    <= '0;
      out_done_q <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign status_o.rotate     = rotate_q;
  assign status_o.r_zero     = (r_q == '0);
  assign status_o.big_ratio  = {2'b0, lmag} >= {rmag, 2'b00};
  assign status_o.within_tol = emag <= {17'b0, tol_q};
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = out_l_q;
  assign right_drive_o = out_r_q;
  assign move_done_o   = out_done_q;
  assign last_o        = out_last_q;

  `PWMC_ASSERT(a_c_range, (c_q <= pwmc_pkg::C_MAX) && (c_q >= pwmc_pkg::C_MIN), "balance out of range")
  `PWMC_ASSERT(a_stop_out, (cmd_i.op == pwmc_pkg::DP_EMIT_STOP) |=> (out_valid_q && out_done_q && out_last_q), "stop not shown")
  `PWMC_ASSERT(a_drive_out, (cmd_i.op == pwmc_pkg::DP_EMIT_DRIVE) |=> (out_valid_q && !out_done_q), "drive not shown")

endmodule

// ===== design/pwmc_ctrl.sv =====
`include "pid_wheel_move_controller_assert.svh"

module pwmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  input  pwmc_pkg::dp_status_t status_i,
  output pwmc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_ERR   = 15'h0002,
    ST_MP    = 15'h0004,
    ST_MI    = 15'h0008,
    ST_MD    = 15'h0010,
    ST_MACC  = 15'h0020,
    ST_CLAMP = 15'h0040,
    ST_DIVI  = 15'h0080,
    ST_DIV   = 15'h0100,
    ST_CSET  = 15'h0200,
    ST_MA    = 15'h0400,
    ST_MB    = 15'h0800,
    ST_FINB  = 15'h1000,
    ST_EMIT  = 15'h2000,
    ST_STOP  = 15'h4000
  } state_e;

  state_e      state_q, state_d;
  logic        active_q, active_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign xfer       = in_valid_i && in_ready_o;

  // sequence a start, or one sample through error, PID, balance, emit and stop
  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    cnt_d      = cnt_q;
    cmd_o.op   = pwmc_pkg::DP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (xfer && !in_kind_i) begin
          cmd_o.op = pwmc_pkg::DP_START;
          active_d = 1'b1;
        end else if (xfer && active_q) begin
          cmd_o.op = pwmc_pkg::DP_LOAD;
          state_d  = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.op = pwmc_pkg::DP_ERR;
        state_d  = ST_MP;
      end
      ST_MP: begin
        cmd_o.op = pwmc_pkg::DP_MUL_P;
        state_d  = ST_MI;
      end
      ST_MI: begin
        cmd_o.op = pwmc_pkg::DP_MUL_I;
        state_d  = ST_MD;
      end
      ST_MD: begin
        cmd_o.op = pwmc_pkg::DP_MUL_D;
        state_d  = ST_MACC;
      end
      ST_MACC: begin
        cmd_o.op = pwmc_pkg::DP_ACC;
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.op = pwmc_pkg::DP_CLAMP;
        if (!status_i.rotate) begin
          state_d = ST_EMIT;
        end else if (status_i.r_zero) begin
          state_d = ST_MA;
        end else begin
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        if (status_i.big_ratio) begin
          cmd_o.op = pwmc_pkg::DP_C_SAT;
          state_d  = ST_MA;
        end else begin
          cmd_o.op = pwmc_pkg::DP_DIV_INIT;
          cnt_d    = 5'd17;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.op = pwmc_pkg::DP_DIV_STEP;
        if (cnt_q == 5'd0) begin
          state_d = ST_CSET;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      ST_CSET: begin
        cmd_o.op = pwmc_pkg::DP_CSET;
        state_d  = ST_MA;
      end
      ST_MA: begin
        cmd_o.op = pwmc_pkg::DP_MUL_A;
        state_d  = ST_MB;
      end
      ST_MB: begin
        cmd_o.op = pwmc_pkg::DP_MUL_B;
        state_d  = ST_FINB;
      end
      ST_FINB: begin
        cmd_o.op = pwmc_pkg::DP_FIN_B;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = pwmc_pkg::DP_EMIT_DRIVE;
          if (status_i.within_tol) begin
            active_d = 1'b0;
            state_d  = ST_STOP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STOP: begin
        if (status_i.out_free) begin
          cmd_o.op = pwmc_pkg::DP_EMIT_STOP;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  `PWMC_ASSERT(a_stop_idle, (state_q == ST_STOP) |-> !active_q, "stop while move active")
  `PWMC_ASSERT_NEVER(a_cnt_range, (state_q == ST_DIV) && (cnt_q > 5'd17), "divider count overrun")
  `PWMC_ASSERT(a_done_stop, (state_q == ST_EMIT && status_i.out_free && status_i.within_tol) |=> (state_q == ST_STOP), "finished move without stop")

endmodule
